// File: hw/rtl/mbs_pkg.sv
package mbs_pkg;

   localparam int HOLDING_COUNT = 32;
   localparam int INPUT_COUNT   = 32;
   localparam int RX_BYTES      = 128;
   localparam int TX_BYTES      = 64;

   localparam int HOLD_AW  = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
   localparam int INPUT_AW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
   localparam int RX_AW    = $clog2(RX_BYTES);
   localparam int CNT_W    = $clog2(RX_BYTES + 1);

   localparam logic [7:0] MIN_FRAME     = 8'd7;
   localparam logic [7:0] EXC_FLAG      = 8'h80;
   localparam logic [7:0] FC_READ_HOLD  = 8'd3;
   localparam logic [7:0] FC_READ_INPUT = 8'd4;
   localparam logic [7:0] FC_WRITE_MULT = 8'd16;
   localparam logic [7:0] EXC_BAD_FUNC  = 8'd1;
   localparam logic [7:0] EXC_BAD_START = 8'd2;
   localparam logic [7:0] EXC_BAD_COUNT = 8'd3;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SILENCE_LIMIT  = 2'd1;

   typedef enum logic [2:0] {
      CMD_RX      = 3'd0,
      CMD_TICK    = 3'd1,
      CMD_WR_IN   = 3'd2,
      CMD_WR_HOLD = 3'd3,
      CMD_RD_HOLD = 3'd4
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [7:0]  rx_byte;
      logic [7:0]  index;
      logic [15:0] value;
      logic        ok;
   } cmd_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic [15:0] local_value;
      logic        local_ok;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LRD, ST_LOCAL, ST_SCAN_RD, ST_SCAN_DAT, ST_CHECK,
      ST_WR_HI, ST_WR_LO, ST_WR_PUT, ST_HDR, ST_REG_RD, ST_REG_DAT,
      ST_REG_HI, ST_REG_LO, ST_CRC_LO, ST_CRC_HI
   } st_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) c = (c >> 1) ^ 16'hA001;
         else c = c >> 1;
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/mbs_ram.sv
module mbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: hw/rtl/mbs_front.sv
module mbs_front (
   input  logic            push,
   input  logic [2:0]      req_func,
   input  logic [7:0]      req_rx_byte,
   input  logic [7:0]      req_reg_index,
   input  logic [15:0]     req_reg_value,
   input  logic            q_full,
   output logic            full,
   output logic            q_push,
   output mbs_pkg::cmd_type q_data
);
   logic known;

   always_comb begin
      known = 1'b1;
      q_data.op = mbs_pkg::CMD_RX;
      q_data.ok = 1'b0;
      case (req_func)
         3'd0: q_data.op = mbs_pkg::CMD_RX;
         3'd1: q_data.op = mbs_pkg::CMD_TICK;
         3'd2: begin
            q_data.op = mbs_pkg::CMD_WR_IN;
            q_data.ok = 9'(req_reg_index) < 9'(mbs_pkg::INPUT_COUNT);
         end
         3'd3: begin
            q_data.op = mbs_pkg::CMD_WR_HOLD;
            q_data.ok = 9'(req_reg_index) < 9'(mbs_pkg::HOLDING_COUNT);
         end
         3'd4: begin
            q_data.op = mbs_pkg::CMD_RD_HOLD;
            q_data.ok = 9'(req_reg_index) < 9'(mbs_pkg::HOLDING_COUNT);
         end
         default: known = 1'b0;
      endcase
      q_data.rx_byte = req_rx_byte;
      q_data.index   = req_reg_index;
      q_data.value   = req_reg_value;
   end

   assign full   = q_full;
   // drop unknown requests here, they never reach the back end
   assign q_push = push && !q_full && known;
endmodule

// File: hw/rtl/mbs_cmd_q.sv
module mbs_cmd_q (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mbs_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output mbs_pkg::cmd_type pop_data
);
   mbs_pkg::cmd_type ent_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) ent_ff[wp_ff] <= push_data;
   end

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = ent_ff[rp_ff];
endmodule

// File: hw/rtl/mbs_back.sv
module mbs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       dev_addr,
   input  logic [7:0]       sil_lim,
   input  logic             q_empty,
   input  mbs_pkg::cmd_type q_data,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output mbs_pkg::rsp_type rsp
);
   localparam int CW = mbs_pkg::CNT_W;
   localparam int AW = mbs_pkg::RX_AW;

   mbs_pkg::st_type st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in, fn_ff, fn_in, idx_ff, idx_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    sil_ff, sil_in, sil_nx;
   logic [15:0]   crc_ff, crc_in, rcrc_ff, rcrc_in;
   logic [7:0]    hdr_ff [6];
   logic [7:0]    hdr_in [6];
   logic [2:0]    hi_ff, hi_in, rlen_ff, rlen_in;
   logic [7:0]    start_ff, start_in, rcnt_ff, rcnt_in, ri_ff, ri_in, wh_ff, wh_in;
   logic          is_in_ff, is_in_in, body_ff, body_in, rv_ff, rv_in;
   logic [15:0]   word_ff, word_in, lval_ff, lval_in;
   logic          lok_ff, lok_in;
   logic          out_vld_ff, out_vld_in, out_free;
   mbs_pkg::rsp_type out_ff, out_in;
   logic [mbs_pkg::HOLDING_COUNT-1:0] hv_ff, hv_in;
   logic [mbs_pkg::INPUT_COUNT-1:0]   iv_ff, iv_in;

   logic                       b_we;
   logic [mbs_pkg::RX_AW-1:0]  b_waddr, b_raddr;
   logic [7:0]                 b_wdata, b_rdata;
   logic                       h_we;
   logic [mbs_pkg::HOLD_AW-1:0] h_waddr, h_raddr;
   logic [15:0]                h_wdata, h_rdata;
   logic                       i_we;
   logic [mbs_pkg::INPUT_AW-1:0] i_waddr, i_raddr;
   logic [15:0]                i_rdata;

   logic [7:0]  fc, code;
   logic [15:0] f_start, f_cnt;
   logic [8:0]  lim;
   logic [7:0]  reg_addr, tx_b, ridx_next;
   logic        emit, emit_last;

   mbs_ram #(.WIDTH(8), .DEPTH(mbs_pkg::RX_BYTES)) u_buf (
      .clock(clock), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
      .raddr(b_raddr), .rdata(b_rdata));
   mbs_ram #(.WIDTH(16), .DEPTH(mbs_pkg::HOLDING_COUNT)) u_hold (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata));
   mbs_ram #(.WIDTH(16), .DEPTH(mbs_pkg::INPUT_COUNT)) u_inr (
      .clock(clock), .we(i_we), .waddr(i_waddr), .wdata(q_data.value),
      .raddr(i_raddr), .rdata(i_rdata));

   assign out_free  = !out_vld_ff || pop;
   assign sil_nx    = (sil_ff == 8'hFF) ? sil_ff : sil_ff + 8'd1;
   assign reg_addr  = start_ff + ri_ff;
   assign ridx_next = ri_ff + 8'd1;

   always_comb begin
      fc      = hdr_ff[1];
      f_start = {hdr_ff[2], hdr_ff[3]};
      f_cnt   = {hdr_ff[4], hdr_ff[5]};
      lim     = (fc == mbs_pkg::FC_READ_INPUT) ? 9'(mbs_pkg::INPUT_COUNT)
                                               : 9'(mbs_pkg::HOLDING_COUNT);
      code    = 8'd0;
      if (fc == mbs_pkg::FC_READ_HOLD || fc == mbs_pkg::FC_READ_INPUT ||
          fc == mbs_pkg::FC_WRITE_MULT) begin
         if (17'(f_start) >= 17'(lim)) code = mbs_pkg::EXC_BAD_START;
         else if (f_cnt == 16'd0 || 17'(f_start) + 17'(f_cnt) > 17'(lim) ||
                  18'({f_cnt, 1'b0}) + 18'd5 > 18'(mbs_pkg::TX_BYTES))
            code = mbs_pkg::EXC_BAD_COUNT;
         else if (fc == mbs_pkg::FC_WRITE_MULT &&
                  18'(fn_ff) != 18'({f_cnt, 1'b0}) + 18'd9)
            code = mbs_pkg::EXC_BAD_COUNT;
      end else begin
         code = mbs_pkg::EXC_BAD_FUNC;
      end
   end

   always_comb begin
      st_in = st_ff;   cnt_in = cnt_ff; fn_in = fn_ff;   idx_in = idx_ff;
      ovf_in = ovf_ff; sil_in = sil_ff; crc_in = crc_ff; rcrc_in = rcrc_ff;
      hdr_in = hdr_ff; hi_in = hi_ff;   rlen_in = rlen_ff;
      start_in = start_ff; rcnt_in = rcnt_ff; ri_in = ri_ff; wh_in = wh_ff;
      is_in_in = is_in_ff; body_in = body_ff; rv_in = rv_ff; word_in = word_ff;
      lval_in = lval_ff; lok_in = lok_ff; hv_in = hv_ff; iv_in = iv_ff;
      out_vld_in = out_vld_ff && !pop;
      out_in = out_ff;
      q_pop = 1'b0;
      b_we = 1'b0; b_waddr = cnt_ff[mbs_pkg::RX_AW-1:0]; b_wdata = q_data.rx_byte;
      b_raddr = idx_ff[mbs_pkg::RX_AW-1:0];
      h_we = 1'b0; h_waddr = q_data.index[mbs_pkg::HOLD_AW-1:0]; h_wdata = q_data.value;
      h_raddr = reg_addr[mbs_pkg::HOLD_AW-1:0];
      i_we = 1'b0; i_waddr = q_data.index[mbs_pkg::INPUT_AW-1:0];
      i_raddr = reg_addr[mbs_pkg::INPUT_AW-1:0];
      emit = 1'b0; emit_last = 1'b0; tx_b = hdr_ff[hi_ff];

      case (st_ff)
         mbs_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_data.op)
                  mbs_pkg::CMD_RX: begin
                     if (cnt_ff < CW'(mbs_pkg::RX_BYTES)) begin
                        b_we   = 1'b1;
                        cnt_in = cnt_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                     sil_in = 8'd0;
                  end
                  mbs_pkg::CMD_TICK: begin
                     if (cnt_ff != CW'(0)) begin
                        if (sil_nx <= sil_lim) begin
                           sil_in = sil_nx;
                        end else begin
                           // frame end: take a snapshot of the length, empty the buffer
                           sil_in = 8'd0;
                           cnt_in = CW'(0);
                           ovf_in = 1'b0;
                           fn_in  = cnt_ff;
                           idx_in = CW'(0);
                           crc_in = 16'hFFFF;
                           if (!ovf_ff && cnt_ff >= CW'(mbs_pkg::MIN_FRAME))
                              st_in = mbs_pkg::ST_SCAN_RD;
                        end
                     end
                  end
                  mbs_pkg::CMD_WR_IN: begin
                     lval_in = 16'd0;
                     lok_in  = q_data.ok;
                     if (q_data.ok) begin
                        i_we = 1'b1;
                        iv_in[i_waddr] = 1'b1;
                     end
                     st_in = mbs_pkg::ST_LOCAL;
                  end
                  mbs_pkg::CMD_WR_HOLD: begin
                     lval_in = 16'd0;
                     lok_in  = q_data.ok;
                     if (q_data.ok) begin
                        h_we = 1'b1;
                        hv_in[h_waddr] = 1'b1;
                     end
                     st_in = mbs_pkg::ST_LOCAL;
                  end
                  mbs_pkg::CMD_RD_HOLD: begin
                     lval_in = 16'd0;
                     lok_in  = q_data.ok;
                     h_raddr = q_data.index[mbs_pkg::HOLD_AW-1:0];
                     rv_in   = hv_ff[h_raddr];
                     st_in   = q_data.ok ? mbs_pkg::ST_LRD : mbs_pkg::ST_LOCAL;
                  end
                  default: ;
               endcase
            end
         end
         mbs_pkg::ST_LRD: begin
            lval_in = rv_ff ? h_rdata : 16'd0;
            st_in   = mbs_pkg::ST_LOCAL;
         end
         mbs_pkg::ST_LOCAL: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in = '{kind: 1'b1, tx_byte: 8'd0, tx_last: 1'b0,
                          local_value: lval_ff, local_ok: lok_ff};
               st_in = mbs_pkg::ST_IDLE;
            end
         end
         mbs_pkg::ST_SCAN_RD: st_in = mbs_pkg::ST_SCAN_DAT;
         mbs_pkg::ST_SCAN_DAT: begin
            if (idx_ff < CW'(6)) hdr_in[idx_ff[2:0]] = b_rdata;
            if (idx_ff < fn_ff - CW'(2)) crc_in = mbs_pkg::crc_byte(crc_ff, b_rdata);
            if (idx_ff == fn_ff - CW'(2)) rcrc_in[7:0] = b_rdata;
            if (idx_ff == fn_ff - CW'(1)) begin
               rcrc_in[15:8] = b_rdata;
               st_in = mbs_pkg::ST_CHECK;
            end else begin
               st_in = mbs_pkg::ST_SCAN_RD;
            end
            idx_in = idx_ff + CW'(1);
         end
         mbs_pkg::ST_CHECK: begin
            start_in = f_start[7:0];
            rcnt_in  = f_cnt[7:0];
            ri_in    = 8'd0;
            hi_in    = 3'd0;
            crc_in   = 16'hFFFF;
            is_in_in = fc == mbs_pkg::FC_READ_INPUT;
            body_in  = 1'b0;
            rlen_in  = 3'd3;
            if (hdr_ff[0] != dev_addr || rcrc_ff != crc_ff) begin
               st_in = mbs_pkg::ST_IDLE;
            end else if (code != 8'd0) begin
               hdr_in[1] = fc | mbs_pkg::EXC_FLAG;
               hdr_in[2] = code;
               st_in = mbs_pkg::ST_HDR;
            end else if (fc == mbs_pkg::FC_WRITE_MULT) begin
               rlen_in = 3'd6;
               st_in = mbs_pkg::ST_WR_HI;
            end else begin
               hdr_in[2] = {f_cnt[6:0], 1'b0};
               body_in = 1'b1;
               st_in = mbs_pkg::ST_HDR;
            end
         end
         mbs_pkg::ST_WR_HI: begin
            b_raddr = AW'(7) + AW'({ri_ff, 1'b0});
            st_in = mbs_pkg::ST_WR_LO;
         end
         mbs_pkg::ST_WR_LO: begin
            wh_in   = b_rdata;
            b_raddr = AW'(8) + AW'({ri_ff, 1'b0});
            st_in = mbs_pkg::ST_WR_PUT;
         end
         mbs_pkg::ST_WR_PUT: begin
            h_we    = 1'b1;
            h_waddr = reg_addr[mbs_pkg::HOLD_AW-1:0];
            h_wdata = {wh_ff, b_rdata};
            hv_in[h_waddr] = 1'b1;
            ri_in = ridx_next;
            st_in = (ridx_next == rcnt_ff) ? mbs_pkg::ST_HDR : mbs_pkg::ST_WR_HI;
         end
         mbs_pkg::ST_HDR: begin
            emit = 1'b1;
            if (out_free) begin
               hi_in = hi_ff + 3'd1;
               if (hi_ff == rlen_ff - 3'd1) begin
                  ri_in = 8'd0;
                  st_in = body_ff ? mbs_pkg::ST_REG_RD : mbs_pkg::ST_CRC_LO;
               end
            end
         end
         mbs_pkg::ST_REG_RD: begin
            rv_in = is_in_ff ? iv_ff[i_raddr] : hv_ff[h_raddr];
            st_in = mbs_pkg::ST_REG_DAT;
         end
         mbs_pkg::ST_REG_DAT: begin
            word_in = !rv_ff ? 16'd0 : (is_in_ff ? i_rdata : h_rdata);
            st_in = mbs_pkg::ST_REG_HI;
         end
         mbs_pkg::ST_REG_HI: begin
            emit = 1'b1;
            tx_b = word_ff[15:8];
            if (out_free) st_in = mbs_pkg::ST_REG_LO;
         end
         mbs_pkg::ST_REG_LO: begin
            emit = 1'b1;
            tx_b = word_ff[7:0];
            if (out_free) begin
               ri_in = ridx_next;
               st_in = (ridx_next == rcnt_ff) ? mbs_pkg::ST_CRC_LO : mbs_pkg::ST_REG_RD;
            end
         end
         mbs_pkg::ST_CRC_LO: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in = '{kind: 1'b0, tx_byte: crc_ff[7:0], tx_last: 1'b0,
                          local_value: 16'd0, local_ok: 1'b0};
               st_in = mbs_pkg::ST_CRC_HI;
            end
         end
         mbs_pkg::ST_CRC_HI: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_in = '{kind: 1'b0, tx_byte: crc_ff[15:8], tx_last: 1'b1,
                          local_value: 16'd0, local_ok: 1'b0};
               st_in = mbs_pkg::ST_IDLE;
            end
         end
         default: st_in = mbs_pkg::ST_IDLE;
      endcase

      // reply byte: send it and fold it into the outgoing CRC
      if (emit && out_free) begin
         out_vld_in = 1'b1;
         out_in = '{kind: 1'b0, tx_byte: tx_b, tx_last: emit_last,
                    local_value: 16'd0, local_ok: 1'b0};
         crc_in = mbs_pkg::crc_byte(crc_ff, tx_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= mbs_pkg::ST_IDLE;
         cnt_ff     <= CW'(0);
         ovf_ff     <= 1'b0;
         sil_ff     <= 8'd0;
         hv_ff      <= '0;
         iv_ff      <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
         sil_ff     <= sil_in;
         hv_ff      <= hv_in;
         iv_ff      <= iv_in;
         out_vld_ff <= out_vld_in;
      end
      fn_ff <= fn_in;     idx_ff <= idx_in;   crc_ff <= crc_in;   rcrc_ff <= rcrc_in;
      hdr_ff <= hdr_in;   hi_ff <= hi_in;     rlen_ff <= rlen_in;
      start_ff <= start_in; rcnt_ff <= rcnt_in; ri_ff <= ri_in;   wh_ff <= wh_in;
      is_in_ff <= is_in_in; body_ff <= body_in; rv_ff <= rv_in;   word_ff <= word_in;
      lval_ff <= lval_in; lok_ff <= lok_in;   out_ff <= out_in;
   end

   assign empty = !out_vld_ff;
   assign rsp   = out_ff;
endmodule

// File: hw/rtl/modbus_rtu_slave.sv
// Modbus RTU slave, functions 3, 4 and 16, with local register access.
// Request channel: push/full. A request carries req_func (0 serial byte,
// 1 millisecond tick, 2 write input reg, 3 write holding reg, 4 read holding
// reg) with its byte, index and value. Codes 5 to 7 are taken and dropped.
// Response channel: empty/pop. Each response is a reply byte (kind 0, CRC low
// byte first, tx_last on the final one) or a local answer (kind 1).
// Configuration: csr_valid/csr_ready with csr_index (0 device address,
// 1 silence limit) and csr_data; csr_ready is always high.
// A byte or tick is handled in ST_IDLE; a local read adds ST_LRD. At a frame
// end the receive buffer is walked byte by byte through its single read port
// (SCAN_RD, SCAN_DAT); header and CRC bytes go out 1 per cycle unless the
// receiver stalls. Registers go through REG_RD/DAT/HI/LO or WR_HI/LO/PUT.
// A two-entry request queue lets requests arrive while the back end works.
// When the receiver stalls the response register holds and the back end waits.
// Reset empties the frame buffer, zeroes both register stores and sets the
// device address to 0 and the silence limit to 2; no clearing pass is needed.
module modbus_rtu_slave (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_reg_index,
   input  logic [15:0] req_reg_value,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic [15:0] rsp_local_value,
   output logic        rsp_local_ok,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]  csr_data
);
   logic [7:0] dev_addr_ff, dev_addr_in, sil_lim_ff, sil_lim_in;
   logic q_push, q_full, q_pop, q_empty;
   mbs_pkg::cmd_type q_in, q_out;
   mbs_pkg::rsp_type rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      dev_addr_in = dev_addr_ff;
      sil_lim_in  = sil_lim_ff;
      if (csr_valid) begin
         case (csr_index)
            mbs_pkg::CSR_DEVICE_ADDRESS: dev_addr_in = csr_data;
            mbs_pkg::CSR_SILENCE_LIMIT:  sil_lim_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= 8'd0;
         sil_lim_ff  <= 8'd2;
      end else begin
         dev_addr_ff <= dev_addr_in;
         sil_lim_ff  <= sil_lim_in;
      end
   end

   mbs_front u_front (
      .push(push), .req_func(req_func), .req_rx_byte(req_rx_byte),
      .req_reg_index(req_reg_index), .req_reg_value(req_reg_value),
      .q_full(q_full), .full(full), .q_push(q_push), .q_data(q_in));

   mbs_cmd_q u_q (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_data(q_out));

   mbs_back u_back (
      .clock(clock), .reset(reset), .dev_addr(dev_addr_ff), .sil_lim(sil_lim_ff),
      .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
      .pop(pop), .empty(empty), .rsp(rsp));

   assign rsp_kind        = rsp.kind;
   assign rsp_tx_byte     = rsp.tx_byte;
   assign rsp_tx_last     = rsp.tx_last;
   assign rsp_local_value = rsp.local_value;
   assign rsp_local_ok    = rsp.local_ok;

`ifndef SYNTHESIS
   a_local_not_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_kind |-> !rsp_tx_last)
      else $error("local answer flagged as last reply byte");
   a_reply_clean: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_kind |-> !rsp_local_ok && rsp_local_value == 16'd0)
      else $error("reply byte carries local answer fields");
   a_no_pop_empty_q: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end took a request from an empty queue");
`endif
endmodule

// File: tb/sv/tb_modbus_rtu_slave.sv
`timescale 1ns / 100ps

module tb_modbus_rtu_slave;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [2:0]  req_func = '0;
   logic [7:0]  req_rx_byte = '0;
   logic [7:0]  req_reg_index = '0;
   logic [15:0] req_reg_value = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic [15:0] rsp_local_value;
   logic        rsp_local_ok;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [mbs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0]  csr_data = '0;

   modbus_rtu_slave uut (.*);

   always #2 clock = ~clock;

   // slave model state
   logic [7:0]  frame_buf [mbs_pkg::RX_BYTES];
   int          frame_len;
   bit          frame_ovf;
   int          quiet_ticks;
   logic [15:0] hold_mem [mbs_pkg::HOLDING_COUNT];
   logic [15:0] input_mem [mbs_pkg::INPUT_COUNT];
   logic [7:0]  my_addr;
   logic [7:0]  quiet_limit;

   mbs_pkg::rsp_type reply_q [$];
   int          mismatches = 0;
   bit          calm = 1'b0;
   logic        long_hold = 1'b0;
   int          rx_wait = 0;

   function automatic logic [15:0] modbus_crc(input logic [7:0] b [$]);
      logic [15:0] c;
      c = 16'hFFFF;
      foreach (b[i]) begin
         c = c ^ {8'h00, b[i]};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void add_reply(logic k, logic [7:0] tb, logic tl, logic [15:0] lv,
                                     logic lo);
      mbs_pkg::rsp_type r;
      r.kind = k; r.tx_byte = tb; r.tx_last = tl; r.local_value = lv; r.local_ok = lo;
      reply_q.push_back(r);
   endfunction

   // handle a completed frame, queue the reply bytes it produces
   function automatic void end_frame();
      logic [7:0]  body [$];
      logic [7:0]  rep [$];
      logic [7:0]  fc, code;
      int          n, start, cnt, lim;
      logic [15:0] crc, v;
      n = frame_len;
      code = 8'd0;
      if (frame_ovf || n < 7 || frame_buf[0] != my_addr) return;
      for (int i = 0; i < n - 2; i++) body.push_back(frame_buf[i]);
      if (modbus_crc(body) != {frame_buf[n-1], frame_buf[n-2]}) return;
      fc = frame_buf[1];
      start = {frame_buf[2], frame_buf[3]};
      cnt = {frame_buf[4], frame_buf[5]};
      if (fc == mbs_pkg::FC_READ_HOLD || fc == mbs_pkg::FC_READ_INPUT ||
          fc == mbs_pkg::FC_WRITE_MULT) begin
         lim = (fc == mbs_pkg::FC_READ_INPUT) ? mbs_pkg::INPUT_COUNT
                                              : mbs_pkg::HOLDING_COUNT;
         if (start >= lim) code = mbs_pkg::EXC_BAD_START;
         else if (cnt == 0 || start + cnt > lim || 2 * cnt + 5 > mbs_pkg::TX_BYTES)
            code = mbs_pkg::EXC_BAD_COUNT;
         else if (fc == mbs_pkg::FC_WRITE_MULT && n != 9 + 2 * cnt)
            code = mbs_pkg::EXC_BAD_COUNT;
      end else begin
         code = mbs_pkg::EXC_BAD_FUNC;
      end
      if (code != 8'd0) begin
         rep = '{frame_buf[0], fc | mbs_pkg::EXC_FLAG, code};
      end else if (fc == mbs_pkg::FC_WRITE_MULT) begin
         for (int i = 0; i < cnt; i++)
            hold_mem[start + i] = {frame_buf[7 + 2 * i], frame_buf[8 + 2 * i]};
         for (int i = 0; i < 6; i++) rep.push_back(frame_buf[i]);
      end else begin
         rep = '{frame_buf[0], fc, 8'(2 * cnt)};
         for (int i = 0; i < cnt; i++) begin
            v = (fc == mbs_pkg::FC_READ_INPUT) ? input_mem[start + i] : hold_mem[start + i];
            rep.push_back(v[15:8]);
            rep.push_back(v[7:0]);
         end
      end
      crc = modbus_crc(rep);
      foreach (rep[i]) add_reply(1'b0, rep[i], 1'b0, 16'h0, 1'b0);
      add_reply(1'b0, crc[7:0], 1'b0, 16'h0, 1'b0);
      add_reply(1'b0, crc[15:8], 1'b1, 16'h0, 1'b0);
   endfunction

   function automatic void model_request(logic [2:0] f, logic [7:0] b, logic [7:0] idx,
                                         logic [15:0] val);
      case (f)
         mbs_pkg::CMD_RX: begin
            if (frame_len < mbs_pkg::RX_BYTES) begin
               frame_buf[frame_len] = b;
               frame_len++;
            end else frame_ovf = 1'b1;
            quiet_ticks = 0;
         end
         mbs_pkg::CMD_TICK: begin
            if (frame_len != 0) begin
               if (quiet_ticks < 255) quiet_ticks++;
               if (quiet_ticks > quiet_limit) begin
                  end_frame();
                  frame_len = 0;
                  frame_ovf = 1'b0;
                  quiet_ticks = 0;
               end
            end
         end
         mbs_pkg::CMD_WR_IN: begin
            if (idx < mbs_pkg::INPUT_COUNT) input_mem[idx] = val;
            add_reply(1'b1, 8'h0, 1'b0, 16'h0, idx < mbs_pkg::INPUT_COUNT);
         end
         mbs_pkg::CMD_WR_HOLD: begin
            if (idx < mbs_pkg::HOLDING_COUNT) hold_mem[idx] = val;
            add_reply(1'b1, 8'h0, 1'b0, 16'h0, idx < mbs_pkg::HOLDING_COUNT);
         end
         mbs_pkg::CMD_RD_HOLD: begin
            if (idx < mbs_pkg::HOLDING_COUNT)
               add_reply(1'b1, 8'h0, 1'b0, hold_mem[idx], 1'b1);
            else add_reply(1'b1, 8'h0, 1'b0, 16'h0, 1'b0);
         end
         default: ;
      endcase
   endfunction

   task automatic send_req(logic [2:0] f, logic [7:0] b, logic [7:0] idx, logic [15:0] val);
      int gap;
      push <= 1'b1;
      req_func <= f;
      req_rx_byte <= b;
      req_reg_index <= idx;
      req_reg_value <= val;
      do @(posedge clock); while (full);
      model_request(f, b, idx, val);
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_tick();
      send_req(mbs_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   // send a frame byte by byte, then tick until the slave ends it
   task automatic send_frame(logic [7:0] fr [$]);
      int guard;
      guard = 0;
      foreach (fr[i]) send_req(mbs_pkg::CMD_RX, fr[i], 8'($urandom), 16'($urandom));
      while (frame_len != 0 && quiet_limit != 8'd255 && guard < 300) begin
         send_tick();
         guard++;
      end
   endtask

   function automatic void build_frame(ref logic [7:0] fr [$], input logic [7:0] a,
                                       logic [7:0] fc, logic [15:0] st, logic [15:0] cnt,
                                       int data_bytes, bit bad_crc);
      logic [15:0] crc;
      fr = '{a, fc, st[15:8], st[7:0], cnt[15:8], cnt[7:0]};
      if (fc == mbs_pkg::FC_WRITE_MULT) fr.push_back(8'(2 * cnt));
      for (int i = 0; i < data_bytes; i++) fr.push_back(8'($urandom));
      crc = modbus_crc(fr);
      if (bad_crc) crc = crc ^ 16'h0100;
      fr.push_back(crc[7:0]);
      fr.push_back(crc[15:8]);
   endfunction

   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (reply_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [mbs_pkg::CSR_IDX_W-1:0] idx, logic [7:0] d);
      drain();
      // let a dropped frame finish its buffer walk
      repeat (400) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == mbs_pkg::CSR_DEVICE_ADDRESS) my_addr = d;
      else if (idx == mbs_pkg::CSR_SILENCE_LIMIT) quiet_limit = d;
   endtask

   task automatic test_local_ports();
      send_req(mbs_pkg::CMD_WR_IN, 8'h00, 8'd0, 16'hFFFF);
      send_req(mbs_pkg::CMD_WR_IN, 8'hFF, 8'd31, 16'h0000);
      send_req(mbs_pkg::CMD_WR_IN, 8'h5A, 8'd32, 16'h1234);
      send_req(mbs_pkg::CMD_WR_HOLD, 8'h00, 8'd0, 16'hFFFF);
      send_req(mbs_pkg::CMD_WR_HOLD, 8'h00, 8'd31, 16'hA5C3);
      send_req(mbs_pkg::CMD_WR_HOLD, 8'h00, 8'd255, 16'h5555);
      send_req(mbs_pkg::CMD_RD_HOLD, 8'h00, 8'd0, 16'h0);
      send_req(mbs_pkg::CMD_RD_HOLD, 8'h00, 8'd31, 16'hFFFF);
      send_req(mbs_pkg::CMD_RD_HOLD, 8'h00, 8'd200, 16'h0);
      send_req(3'd5, 8'hFF, 8'hFF, 16'hFFFF);
      send_req(3'd7, 8'h00, 8'h00, 16'h0);
   endtask

   // one frame ended by the reset silence limit
   task automatic test_default_silence();
      logic [7:0] fr [$];
      build_frame(fr, my_addr, mbs_pkg::FC_READ_HOLD, 16'd30, 16'd2, 0, 0);
      send_frame(fr);
   endtask

   task automatic test_frames();
      logic [7:0] fr [$];
      logic [7:0] a;
      a = my_addr;
      build_frame(fr, a, mbs_pkg::FC_WRITE_MULT, 16'd1, 16'd2, 4, 0);   send_frame(fr);
      build_frame(fr, a, mbs_pkg::FC_READ_HOLD, 16'd0, 16'd3, 0, 0);    send_frame(fr);
      build_frame(fr, a, mbs_pkg::FC_READ_INPUT, 16'd30, 16'd2, 0, 0);  send_frame(fr);
      build_frame(fr, a, 8'd7, 16'd0, 16'd1, 0, 0);                     send_frame(fr);
      build_frame(fr, a, mbs_pkg::FC_READ_INPUT, 16'd32, 16'd1, 0, 0);  send_frame(fr);
      build_frame(fr, a, mbs_pkg::FC_READ_HOLD, 16'd0, 16'd0, 0, 0);    send_frame(fr);
      build_frame(fr, a, mbs_pkg::FC_READ_HOLD, 16'd31, 16'd2, 0, 0);   send_frame(fr);
      build_frame(fr, a, mbs_pkg::FC_READ_HOLD, 16'd0, 16'd30, 0, 0);   send_frame(fr);
      build_frame(fr, a, mbs_pkg::FC_WRITE_MULT, 16'd0, 16'd2, 3, 0);   send_frame(fr);
      build_frame(fr, a, mbs_pkg::FC_READ_HOLD, 16'd0, 16'd1, 0, 1);    send_frame(fr);
      build_frame(fr, ~a, mbs_pkg::FC_READ_HOLD, 16'd0, 16'd1, 0, 0);   send_frame(fr);
      // too short: six bytes
      fr = '{a, mbs_pkg::FC_READ_HOLD, 8'h00, 8'h00, 8'h00, 8'h01};     send_frame(fr);
   endtask

   // a limit of 255 holds a frame however long the line stays silent
   task automatic test_held_frame();
      logic [7:0] fr [$];
      write_csr(mbs_pkg::CSR_SILENCE_LIMIT, 8'd255);
      build_frame(fr, my_addr, mbs_pkg::FC_READ_HOLD, 16'd1, 16'd1, 0, 0);
      send_frame(fr);
      repeat (3) send_tick();
      write_csr(mbs_pkg::CSR_SILENCE_LIMIT, 8'd1);
      while (frame_len != 0) send_tick();
   endtask

   task automatic random_traffic(int n);
      logic [7:0] fr [$];
      logic [7:0] fcs [4];
      int         sel, cnt;
      fcs = '{mbs_pkg::FC_READ_HOLD, mbs_pkg::FC_READ_INPUT, mbs_pkg::FC_WRITE_MULT,
              8'($urandom)};
      repeat (n) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) begin
            cnt = $urandom_range(0, 4);
            build_frame(fr, ($urandom_range(0, 7) == 0) ? 8'($urandom) : my_addr,
                        fcs[$urandom_range(0, 3)],
                        ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 34)),
                        ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'(cnt),
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : 2 * cnt,
                        $urandom_range(0, 9) == 0);
            send_frame(fr);
         end else if (sel < 9) begin
            send_req(3'($urandom_range(2, 4)), 8'($urandom),
                     ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31)),
                     16'($urandom));
         end else begin
            send_req(3'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
         end
      end
   endtask

   task automatic test_backpressure();
      long_hold <= 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            long_hold <= 1'b0;
         end
      join_none
      repeat (12) send_req(mbs_pkg::CMD_RD_HOLD, 8'h00, 8'($urandom_range(0, 40)), 16'h0);
      drain();
   endtask

   // response checker and pop driver
   always @(posedge clock) begin
      mbs_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (reply_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response kind=%0d byte=%h",
                                           rsp_kind, rsp_tx_byte);
         end else begin
            want = reply_q.pop_front();
            if (rsp_kind !== want.kind || rsp_tx_byte !== want.tx_byte ||
                rsp_tx_last !== want.tx_last || rsp_local_value !== want.local_value ||
                rsp_local_ok !== want.local_ok) begin
               mismatches++;
               if (mismatches <= 10)
                  $display(
                     "mismatch exp k=%0d b=%h l=%0d v=%h ok=%0d got k=%0d b=%h l=%0d v=%h ok=%0d",
                     want.kind, want.tx_byte, want.tx_last, want.local_value,
                     want.local_ok, rsp_kind, rsp_tx_byte, rsp_tx_last,
                     rsp_local_value, rsp_local_ok);
            end
         end
      end
      if (rx_wait > 0) rx_wait--;
      else if (!calm && $urandom_range(0, 7) == 0) rx_wait = $urandom_range(1, 13);
      pop <= !reset && !long_hold && !(rx_wait > 0);
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      frame_len = 0;
      frame_ovf = 1'b0;
      quiet_ticks = 0;
      my_addr = 8'd0;
      quiet_limit = 8'd2;
      foreach (hold_mem[i]) hold_mem[i] = '0;
      foreach (input_mem[i]) input_mem[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_local_ports();
      test_default_silence();
      write_csr(mbs_pkg::CSR_DEVICE_ADDRESS, 8'hA7);
      write_csr(mbs_pkg::CSR_SILENCE_LIMIT, 8'd0);
      test_frames();
      test_backpressure();
      test_held_frame();
      write_csr(mbs_pkg::CSR_SILENCE_LIMIT, 8'($urandom_range(0, 3)));
      calm = 1'b1;
      random_traffic(2);

      drain();
      repeat (400) @(posedge clock);
      if (mismatches == 0 && reply_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
